@@ rtl/core/quadrature_edge_speed_meter_unit_defines.svh @@
// Assertion helpers shared by the RTL.
`ifndef QUADRATURE_EDGE_SPEED_METER_UNIT_DEFINES_SVH
`define QUADRATURE_EDGE_SPEED_METER_UNIT_DEFINES_SVH

// expr must hold at every clock edge outside reset
`define QESM_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define QESM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define QESM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/qesm_pkg.sv @@
package qesm_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 32;
   localparam int SPEED_WIDTH     = 32;
   localparam int SCALE_WIDTH     = 31;
   localparam int DIR_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = SCALE_WIDTH;

   // one quotient bit per divider step
   localparam int DIV_STEPS       = SCALE_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS);

   localparam logic [SCALE_WIDTH-1:0] SPEED_SCALE_RESET = 31'd12828768;

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INVERT = 1'b0,
      CSR_SCALE  = 1'b1
   } csr_index_type;

   localparam logic signed [DIR_WIDTH-1:0] DIR_FWD      = 3'sb001;
   localparam logic signed [DIR_WIDTH-1:0] DIR_REV      = 3'sb111;
   localparam logic signed [DIR_WIDTH-1:0] DIR_FWD_FLIP = 3'sb010;
   localparam logic signed [DIR_WIDTH-1:0] DIR_REV_FLIP = 3'sb110;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [SCALE_WIDTH-1:0] dividend;
      logic [TIME_WIDTH-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [SCALE_WIDTH-1:0] quotient;
   } div_sts_type;

endpackage

@@ rtl/core/qesm_req_if.sv @@
interface qesm_req_if;
   logic                            valid;
   logic                            ready;
   logic                            op;
   logic                            phase_a;
   logic                            phase_b;
   logic [qesm_pkg::TIME_WIDTH-1:0] time_us;

   modport source (output valid, op, phase_a, phase_b, time_us, input ready);
   modport sink (input valid, op, phase_a, phase_b, time_us, output ready);
endinterface

@@ rtl/core/qesm_rsp_if.sv @@
interface qesm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [qesm_pkg::COUNT_WIDTH-1:0] position_count;
   logic signed [qesm_pkg::SPEED_WIDTH-1:0] speed;
   logic signed [qesm_pkg::DIR_WIDTH-1:0]   direction;

   modport source (output valid, position_count, speed, direction, input ready);
   modport sink (input valid, position_count, speed, direction, output ready);
endinterface

@@ rtl/core/quadrature_edge_speed_meter_unit.sv @@
// Quadrature edge counter and period-based speed meter.
// req_bus (valid/ready) carries one beat per A-phase edge (op = 0, with the
// sampled A/B levels and a microsecond timestamp) or per query (op = 1, with
// the current time). rsp_bus returns exactly one beat per request: the signed
// count, the speed (deg/s, 4 fraction bits; 0 for edges) and the direction
// mark (+1/-1 steady, +2/-2 right after a reversal).
// csr_* writes invert_direction (index 0) or speed_scale (index 1); write only
// while no request is in flight.
// Timing: one request at a time; req_bus.ready is low from acceptance until
// the response beat is taken. An edge, or a query right after a reversal,
// answers in the cycle after acceptance. A query with a nonzero period
// passes the interval compare (ST_CALC), the one-bit-per-cycle divider
// (ST_DIV) and the hand-off to the response; a zero period skips the divider.
// Reset clears the count and the edge timestamps, sets the mark to +1 and
// loads the default speed_scale. If the receiver stalls, the response holds
// and no new request is taken.
`include "quadrature_edge_speed_meter_unit_defines.svh"

module quadrature_edge_speed_meter_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [qesm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [qesm_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   qesm_req_if.sink                                req_bus,
   qesm_rsp_if.source                              rsp_bus
);

   qesm_pkg::state_type                      state_ff, state_in;
   logic                                     invert_ff;
   logic [qesm_pkg::SCALE_WIDTH-1:0]         scale_ff;
   logic [qesm_pkg::COUNT_WIDTH-1:0]         count_ff, count_in;
   logic signed [qesm_pkg::DIR_WIDTH-1:0]    mark_ff, mark_in;
   logic [qesm_pkg::TIME_WIDTH-1:0]          last_ff, last_in;
   logic [qesm_pkg::TIME_WIDTH-1:0]          prev_ff, prev_in;
   logic [qesm_pkg::TIME_WIDTH-1:0]          now_ff, now_in;
   logic [qesm_pkg::COUNT_WIDTH-1:0]         pos_ff, pos_in;
   logic [qesm_pkg::SPEED_WIDTH-1:0]         speed_ff, speed_in;
   logic signed [qesm_pkg::DIR_WIDTH-1:0]    dir_ff, dir_in;
   logic [qesm_pkg::TIME_WIDTH-1:0]          interval;
   logic [qesm_pkg::TIME_WIDTH-1:0]          since;
   logic [qesm_pkg::TIME_WIDTH-1:0]          dt;
   logic [qesm_pkg::SPEED_WIDTH-1:0]         mag;
   logic                                     req_accept;
   logic                                     forward;
   qesm_pkg::div_ctl_type                    div_ctl;
   qesm_pkg::div_sts_type                    div_sts;

   qesm_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
         scale_ff  <= qesm_pkg::SPEED_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (qesm_pkg::csr_index_type'(csr_index))
            qesm_pkg::CSR_INVERT: invert_ff <= csr_write_data[0];
            qesm_pkg::CSR_SCALE:  scale_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qesm_pkg::ST_IDLE;
         count_ff <= '0;
         mark_ff  <= qesm_pkg::DIR_FWD;
         last_ff  <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mark_ff  <= mark_in;
         last_ff  <= last_in;
         prev_ff  <= prev_in;
      end
      now_ff   <= now_in;
      pos_ff   <= pos_in;
      speed_ff <= speed_in;
      dir_ff   <= dir_in;
   end

   assign req_accept = req_bus.valid && req_bus.ready;
   assign forward    = req_bus.phase_a ^ req_bus.phase_b ^ invert_ff;
   assign interval   = last_ff - prev_ff;
   assign since      = now_ff - last_ff;
   assign dt         = (interval < since) ? interval : since;
   assign mag        = {1'b0, div_sts.quotient};

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      mark_in          = mark_ff;
      last_in          = last_ff;
      prev_in          = prev_ff;
      now_in           = now_ff;
      pos_in           = pos_ff;
      speed_in         = speed_ff;
      dir_in           = dir_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = scale_ff;
      div_ctl.divisor  = dt;
      unique case (state_ff)
         qesm_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_bus.op == qesm_pkg::OP_EDGE) begin
                  prev_in = last_ff;
                  last_in = req_bus.time_us;
                  if (forward) begin
                     count_in = count_ff + 1'b1;
                     mark_in  = mark_ff[qesm_pkg::DIR_WIDTH-1] ? qesm_pkg::DIR_FWD_FLIP
                                                                : qesm_pkg::DIR_FWD;
                  end else begin
                     count_in = count_ff - 1'b1;
                     mark_in  = mark_ff[qesm_pkg::DIR_WIDTH-1] ? qesm_pkg::DIR_REV
                                                                : qesm_pkg::DIR_REV_FLIP;
                  end
                  pos_in   = count_in;
                  speed_in = '0;
                  dir_in   = mark_in;
                  state_in = qesm_pkg::ST_RESP;
               end else if (mark_ff == qesm_pkg::DIR_FWD || mark_ff == qesm_pkg::DIR_REV) begin
                  now_in   = req_bus.time_us;
                  state_in = qesm_pkg::ST_CALC;
               end else begin
                  // reversal still marked: no valid period
                  pos_in   = count_ff;
                  speed_in = '0;
                  dir_in   = mark_ff;
                  state_in = qesm_pkg::ST_RESP;
               end
            end
         end
         qesm_pkg::ST_CALC: begin
            pos_in = count_ff;
            dir_in = mark_ff;
            if (dt == '0) begin
               speed_in = '0;
               state_in = qesm_pkg::ST_RESP;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = qesm_pkg::ST_DIV;
            end
         end
         qesm_pkg::ST_DIV: begin
            if (div_sts.done) begin
               speed_in = mark_ff[qesm_pkg::DIR_WIDTH-1] ? (~mag + 1'b1) : mag;
               state_in = qesm_pkg::ST_RESP;
            end
         end
         qesm_pkg::ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = qesm_pkg::ST_IDLE;
            end
         end
         default: state_in = qesm_pkg::ST_IDLE;
      endcase
   end

   assign req_bus.ready          = (state_ff == qesm_pkg::ST_IDLE);
   assign rsp_bus.valid          = (state_ff == qesm_pkg::ST_RESP);
   assign rsp_bus.position_count = pos_ff;
   assign rsp_bus.speed          = speed_ff;
   assign rsp_bus.direction      = dir_ff;

   `QESM_ASSERT_ALWAYS(a_mark_legal, clock, reset,
      mark_ff == qesm_pkg::DIR_FWD || mark_ff == qesm_pkg::DIR_REV ||
      mark_ff == qesm_pkg::DIR_FWD_FLIP || mark_ff == qesm_pkg::DIR_REV_FLIP,
      "direction mark out of range")
   `QESM_ASSERT_IMPLIES(a_div_done_in_div, clock, reset, div_sts.done,
      state_ff == qesm_pkg::ST_DIV, "divider finished outside divide state")
   `QESM_ASSERT_IMPLIES(a_div_idle_outside, clock, reset,
      state_ff == qesm_pkg::ST_IDLE || state_ff == qesm_pkg::ST_RESP, !div_sts.busy,
      "divider busy while no query in work")
   `QESM_ASSERT_NEXT(a_edge_answers_next, clock, reset,
      req_accept && req_bus.op == qesm_pkg::OP_EDGE, rsp_bus.valid && rsp_bus.speed == '0,
      "edge beat not answered next cycle with zero speed")

endmodule

@@ rtl/core/qesm_divider.sv @@
module qesm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  qesm_pkg::div_ctl_type ctl,
   output qesm_pkg::div_sts_type sts
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [qesm_pkg::DIV_COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [qesm_pkg::TIME_WIDTH-1:0]       rem_ff, rem_in;
   logic [qesm_pkg::SCALE_WIDTH-1:0]      quo_ff, quo_in;
   logic [qesm_pkg::TIME_WIDTH-1:0]       div_ff, div_in;
   logic [qesm_pkg::TIME_WIDTH:0]         trial;
   logic [qesm_pkg::TIME_WIDTH:0]         diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   // restoring division: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial    = {rem_ff, quo_ff[qesm_pkg::SCALE_WIDTH-1]};
      diff     = trial - {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = ctl.dividend;
         div_in   = ctl.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[qesm_pkg::TIME_WIDTH-1:0];
            quo_in = {quo_ff[qesm_pkg::SCALE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[qesm_pkg::TIME_WIDTH-1:0];
            quo_in = {quo_ff[qesm_pkg::SCALE_WIDTH-2:0], 1'b0};
         end
         if (count_ff == qesm_pkg::DIV_COUNT_WIDTH'(qesm_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule
